// ===== rtl/core/assert_macros.svh =====
// Assertion helpers, clocked on clk_i and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");

`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

`endif

// ===== rtl/core/mm4_pkg.sv =====
package mm4_pkg;

  localparam int MATRIX_DIM = 4;
  localparam int FRAC_BITS  = 16;
  localparam int ELEM_COUNT = MATRIX_DIM * MATRIX_DIM;
  localparam int DATA_W     = 32;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int ACC_W      = PROD_W + $clog2(MATRIX_DIM);
  localparam int ADDR_W     = $clog2(ELEM_COUNT);
  localparam int DIM_W      = $clog2(MATRIX_DIM);
  localparam int IDX_W      = 4;

  typedef enum logic {
    ST_LOAD,
    ST_CALC
  } ctrl_state_e;

  // travels with each read through the pipeline
  typedef struct packed {
    logic             first;
    logic             last;
    logic             run_last;
    logic [IDX_W-1:0] elem;
  } tag_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              issue;
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
    tag_t              tag;
  } cmd_t;

  typedef struct packed {
    logic advance;
  } status_t;

endpackage

// ===== rtl/core/mm4_in_if.sv =====
interface mm4_in_if;
  import mm4_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] a_value;
  logic signed [DATA_W-1:0] b_value;

  modport source (output valid, a_value, b_value, input ready);
  modport sink (input valid, a_value, b_value, output ready);
endinterface

// ===== rtl/core/mm4_out_if.sv =====
interface mm4_out_if;
  import mm4_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] product_value;
  logic [IDX_W-1:0]         element_index;
  logic                     last_of_run;

  modport source (output valid, product_value, element_index, last_of_run, input ready);
  modport sink (input valid, product_value, element_index, last_of_run, output ready);
endinterface

// ===== rtl/core/mm4_ram.sv =====
module mm4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/mm4_datapath.sv =====
module mm4_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mm4_pkg::cmd_t                    cmd_i,
  input  logic signed [mm4_pkg::DATA_W-1:0] a_value_i,
  input  logic signed [mm4_pkg::DATA_W-1:0] b_value_i,
  output mm4_pkg::status_t                 status_o,
  mm4_out_if.source                        out_o
);
  import mm4_pkg::*;

  logic                     advance;
  logic signed [DATA_W-1:0] a_rd;
  logic signed [DATA_W-1:0] b_rd;

  logic                     v1_q, v2_q, done3_q;
  tag_t                     tag1_q, tag2_q, tag3_q;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [ACC_W-1:0]  acc_base, acc_d, acc_q;

  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-DATA_W:0]    upper;
  logic                     fits;
  logic signed [DATA_W-1:0] sat_value;

  logic                     out_valid_d, out_valid_q;
  logic signed [DATA_W-1:0] out_value_q;
  logic [IDX_W-1:0]         out_elem_q;
  logic                     out_last_q;

  // whole pipeline freezes while a finished sum cannot move to the output
  assign advance  = !(done3_q && out_valid_q && !out_o.ready);
  assign status_o = '{advance: advance};

  mm4_ram #(.WIDTH(DATA_W), .DEPTH(ELEM_COUNT)) u_left_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.wr_en),
    .wr_addr_i (cmd_i.wr_addr),
    .wr_data_i (a_value_i),
    .rd_en_i   (advance),
    .rd_addr_i (cmd_i.a_addr),
    .rd_data_o (a_rd)
  );

  mm4_ram #(.WIDTH(DATA_W), .DEPTH(ELEM_COUNT)) u_right_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.wr_en),
    .wr_addr_i (cmd_i.wr_addr),
    .wr_data_i (b_value_i),
    .rd_en_i   (advance),
    .rd_addr_i (cmd_i.b_addr),
    .rd_data_o (b_rd)
  );

  assign prod_d   = a_rd * b_rd;
  assign acc_base = tag2_q.first ? {ACC_W{1'b0}} : acc_q;
  assign acc_d    = acc_base + ACC_W'(prod_q);

  assign shifted   = acc_q >>> FRAC_BITS;
  assign upper     = shifted[ACC_W-1:DATA_W-1];
  assign fits      = (&upper) | ~(|upper);
  assign sat_value = fits ? shifted[DATA_W-1:0] :
                     (acc_q[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                     : {1'b0, {(DATA_W-1){1'b1}}});

  always_comb begin
    priority if (advance && done3_q) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      done3_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        v1_q    <= cmd_i.issue;
        v2_q    <= v1_q;
        done3_q <= v2_q && tag2_q.last;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      tag1_q <= cmd_i.tag;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
      prod_q <= prod_d;
      if (v2_q) begin
        acc_q <= acc_d;
      end
      if (done3_q) begin
        out_value_q <= sat_value;
        out_elem_q  <= tag3_q.elem;
        out_last_q  <= tag3_q.run_last;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.product_value = out_value_q;
  assign out_o.element_index = out_elem_q;
  assign out_o.last_of_run   = out_last_q;

endmodule

// ===== rtl/core/mm4_ctrl.sv =====
module mm4_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mm4_pkg::status_t status_i,
  output mm4_pkg::cmd_t    cmd_o
);
  import mm4_pkg::*;

  ctrl_state_e       state_d, state_q;
  logic [ADDR_W-1:0] load_cnt_d, load_cnt_q;
  logic [DIM_W-1:0]  r_d, r_q, i_d, i_q;
  logic [ADDR_W-1:0] c_base_d, c_base_q;
  logic [ADDR_W-1:0] a_addr_d, a_addr_q;
  logic [ADDR_W-1:0] elem_addr;

  logic accept, issue;
  logic load_last, i_last, r_last, c_last;

  assign load_last = load_cnt_q == ADDR_W'(ELEM_COUNT - 1);
  assign i_last    = i_q == DIM_W'(MATRIX_DIM - 1);
  assign r_last    = r_q == DIM_W'(MATRIX_DIM - 1);
  assign c_last    = c_base_q == ADDR_W'(ELEM_COUNT - MATRIX_DIM);
  assign accept    = in_valid_i && in_ready_o;
  assign issue     = (state_q == ST_CALC) && status_i.advance;
  assign elem_addr = c_base_q + ADDR_W'(r_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (accept && load_last) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (issue && i_last && r_last && c_last) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o        = (state_q == ST_LOAD);
    cmd_o.wr_en       = accept;
    cmd_o.wr_addr     = load_cnt_q;
    cmd_o.issue       = issue;
    cmd_o.a_addr      = a_addr_q;
    cmd_o.b_addr      = c_base_q + ADDR_W'(i_q);
    cmd_o.tag.first    = (i_q == '0);
    cmd_o.tag.last     = i_last;
    cmd_o.tag.run_last = r_last && c_last;
    cmd_o.tag.elem     = IDX_W'(elem_addr);
  end

  // index counters
  always_comb begin
    load_cnt_d = load_cnt_q;
    r_d        = r_q;
    i_d        = i_q;
    c_base_d   = c_base_q;
    a_addr_d   = a_addr_q;
    if (accept) begin
      load_cnt_d = load_last ? '0 : load_cnt_q + 1'b1;
    end
    if (issue) begin
      if (i_last) begin
        i_d = '0;
        if (r_last) begin
          r_d      = '0;
          a_addr_d = '0;
          c_base_d = c_last ? '0 : c_base_q + ADDR_W'(MATRIX_DIM);
        end else begin
          r_d      = r_q + 1'b1;
          a_addr_d = ADDR_W'(r_q) + 1'b1;
        end
      end else begin
        i_d      = i_q + 1'b1;
        a_addr_d = a_addr_q + ADDR_W'(MATRIX_DIM);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      r_q        <= '0;
      i_q        <= '0;
      c_base_q   <= '0;
      a_addr_q   <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      r_q        <= r_d;
      i_q        <= i_d;
      c_base_q   <= c_base_d;
      a_addr_q   <= a_addr_d;
    end
  end

endmodule

// ===== rtl/core/matrix4x4_multiply.sv =====
// 4x4 signed Q16.16 matrix multiply, C = A*B, all column-major. Requests carry
// one element of A and of B at the same index, in index order, and are taken
// one per cycle into two 16x32 RAMs; while the product is formed the input
// stalls. One shared 32x32 multiplier and a wide accumulator take one term per
// cycle while the output is not stalled, and the 16 results leave in index
// order, with last_of_run on the final one. Loading and computing do not
// overlap: a run takes all its requests first, then forms the products, paced
// by the single multiply-accumulate and the RAM read port. After the last read
// the final sum passes the RAM data, product, accumulator and output registers.
// Loading of the next matrices starts the cycle after the last read is issued.
// Sums are shifted right by 16 (toward minus infinity) and saturated to 32
// bits. A stalled output freezes the compute pipeline without loss.
`include "assert_macros.svh"

module matrix4x4_multiply (
  input  logic       clk_i,
  input  logic       rst_ni,
  mm4_in_if.sink     in_i,
  mm4_out_if.source  out_o
);
  import mm4_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_i.ready = in_ready;

  mm4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mm4_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .a_value_i (in_i.a_value),
    .b_value_i (in_i.b_value),
    .status_o  (status),
    .out_o     (out_o)
  );

  `ASSERT_IMPLIES(no_load_during_calc, cmd.issue, !in_i.ready)
  `ASSERT_IMPLIES(write_on_accept, cmd.wr_en, in_i.valid && in_i.ready)
  `ASSERT_IMPLIES(stall_needs_block, !status.advance, out_o.valid && !out_o.ready)
  `ASSERT_IMPLIES(last_at_final_index, out_o.valid && out_o.last_of_run,
                  out_o.element_index == IDX_W'(ELEM_COUNT - 1))

endmodule
